[hdl/fbmv_pkg.sv]
// ----------------------------------------------------------------------------
// fbmv_pkg
// Shared types, constants and helper functions for the fractal value noise unit.
// ----------------------------------------------------------------------------
package fbmv_pkg;

    localparam int MAX_OCT   = 8;
    localparam int OCT_W     = 3;
    localparam int FRAC_W    = 16;
    localparam int COORD_W   = 24;
    localparam int FREQ_W    = 32;
    localparam int NOISE_W   = 18;
    localparam int SUM_W     = 26;
    localparam int RECIP_W   = 21;
    localparam int RECIP_SH  = 20;
    localparam int CELL_STG  = 9;

    // register indexes of the configuration port
    localparam logic [1:0] REG_BASE_FREQ = 2'd0;
    localparam logic [1:0] REG_OCT_NUM   = 2'd1;
    localparam logic [1:0] REG_RIDGED    = 2'd2;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] MIX_MULT   = 32'd1274126177;

    typedef logic [MAX_OCT-1:0][FREQ_W-1:0] freq_tab_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [SUM_W-1:0]   sum;
    } carry_t;

    typedef struct packed {
        logic [3:0] oct_num;   // already limited to 0..MAX_OCT
        logic       ridged;
    } cell_cfg_t;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [31:0] v);
        logic [31:0] p;
        p = (h ^ v) * FNV_PRIME;
        return p;
    endfunction

    // a + floor((b - a) * w / 2^16)
    function automatic logic signed [NOISE_W-1:0] blend(input logic signed [NOISE_W-1:0] a,
                                                         input logic signed [NOISE_W-1:0] b,
                                                         input logic [FRAC_W-1:0] w);
        logic signed [NOISE_W:0]   d;
        logic signed [35:0]        p;
        logic signed [NOISE_W+1:0] r;
        d = {b[NOISE_W-1], b} - {a[NOISE_W-1], a};
        p = d * $signed({1'b0, w});
        r = {{2{a[NOISE_W-1]}}, a} + p[35:16];
        return r[NOISE_W-1:0];
    endfunction

    // round(2^20 / (2^k - 1))
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd1:    r = 21'd1048576;
            4'd2:    r = 21'd349525;
            4'd3:    r = 21'd149797;
            4'd4:    r = 21'd69905;
            4'd5:    r = 21'd33825;
            4'd6:    r = 21'd16644;
            4'd7:    r = 21'd8257;
            4'd8:    r = 21'd4112;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/fbmv_freq_gen.sv]
// ----------------------------------------------------------------------------
// fbmv_freq_gen
// Builds the per-octave frequency table from the configuration registers.
// ----------------------------------------------------------------------------
module fbmv_freq_gen
    import fbmv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [23:0]       base_freq,
    input  logic              ridged,
    output logic              busy,
    output freq_tab_t         freq_tab
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [OCT_W-1:0]  idx_reg, idx_next;
    logic [FREQ_W-1:0] fcur_reg, fcur_next;
    logic [FREQ_W-1:0] divx_reg, divx_next;
    logic [FREQ_W-1:0] quo_reg, quo_next;
    logic [2:0]        cnt_reg, cnt_next;
    freq_tab_t         tab_reg, tab_next;

    logic [FREQ_W-1:0] dbl;
    logic [FREQ_W-1:0] rem_lo;
    logic [FREQ_W-1:0] f_ridge;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fcur_next  = fcur_reg;
        divx_next  = divx_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        tab_next   = tab_reg;
        dbl        = {fcur_reg[FREQ_W-2:0], 1'b0};
        // remainder of the tenth estimate, then 2f plus the corrected tenth
        rem_lo     = divx_reg - ((quo_reg << 3) + (quo_reg << 1));
        f_ridge    = dbl + quo_reg + {{(FREQ_W-1){1'b0}}, (rem_lo > FREQ_W'(9))};
        case (state_reg)
            ST_START: begin
                tab_next[0] = {8'd0, base_freq};
                fcur_next   = {8'd0, base_freq};
                idx_next    = 3'd1;
                state_next  = ST_STEP;
            end
            ST_STEP: begin
                if (idx_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (!ridged) begin
                    tab_next[idx_reg] = dbl;
                    fcur_next         = dbl;
                    idx_next          = idx_reg + 3'd1;
                end else begin
                    // (21f + 5) / 10 = 2f + (f + 5) / 10, tenth by shift-and-add
                    divx_next  = fcur_reg + FREQ_W'(5);
                    cnt_next   = 3'd5;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg - 3'd1;
                case (cnt_reg)
                    3'd5: quo_next = (divx_reg >> 1) + (divx_reg >> 2);
                    3'd4: quo_next = quo_reg + (quo_reg >> 4);
                    3'd3: quo_next = quo_reg + (quo_reg >> 8);
                    3'd2: quo_next = quo_reg + (quo_reg >> 16);
                    3'd1: quo_next = quo_reg >> 3;
                    default: begin
                        tab_next[idx_reg] = f_ridge;
                        fcur_next         = f_ridge;
                        idx_next          = idx_reg + 3'd1;
                        state_next        = ST_STEP;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (start) begin
            state_next = ST_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        fcur_reg <= fcur_next;
        divx_reg <= divx_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        tab_reg  <= tab_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign freq_tab = tab_reg;

endmodule

[hdl/fbmv_octave_cell.sv]
// ----------------------------------------------------------------------------
// fbmv_octave_cell
// One octave of value noise: scale, hash eight corners, blend, accumulate.
// ----------------------------------------------------------------------------
module fbmv_octave_cell
    import fbmv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [OCT_W-1:0]  oct_idx,
    input  logic [FREQ_W-1:0] freq,
    input  cell_cfg_t         cfg,
    input  logic              in_vld,
    input  carry_t            in_carry,
    output logic              out_vld,
    output carry_t            out_carry
);

    logic [CELL_STG-1:0] vld_reg;
    carry_t              car_reg [CELL_STG];

    logic [47:0]         prod_reg [3];
    logic [FRAC_W-1:0]   t2_reg [3];
    logic [FRAC_W-1:0]   t_reg [3];
    logic [31:0]         cy_reg, cz_reg, cz3_reg;
    logic [31:0]         hx_reg [2];
    logic [31:0]         hxy_reg [4];
    logic [31:0]         hxyz_reg [8];
    logic [31:0]         hm_reg [8];
    logic [FRAC_W-1:0]   w3_reg [3];
    logic [FRAC_W-1:0]   w4_reg [3];
    logic [FRAC_W-1:0]   w5_reg [3];
    logic [FRAC_W-1:0]   w6_reg [2];
    logic [FRAC_W-1:0]   w7_reg;
    logic signed [NOISE_W-1:0] lx_reg [4];
    logic signed [NOISE_W-1:0] ly_reg [2];
    logic signed [NOISE_W-1:0] n_reg;
    logic signed [NOISE_W-1:0] term_reg;

    logic signed [56:0]  px, py, pz;
    logic signed [NOISE_W-1:0] cv [8];
    logic [NOISE_W-2:0]  n_abs;
    logic [NOISE_W-2:0]  ridge;
    logic [33:0]         ridge_sq;
    logic [2:0]          sh;
    logic                active;
    logic signed [SUM_W-1:0] term_ext;

    assign px = in_carry.x * $signed({1'b0, freq});
    assign py = in_carry.y * $signed({1'b0, freq});
    assign pz = in_carry.z * $signed({1'b0, freq});

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            cv[j] = $signed({1'b0, hm_reg[j][31:15]}) - 18'sd65536;
        end
        n_abs    = n_reg[NOISE_W-1] ? 17'(-n_reg) : n_reg[NOISE_W-2:0];
        ridge    = 17'd65536 - n_abs;
        ridge_sq = 34'(ridge) * 34'(ridge);
        sh       = 3'(cfg.oct_num - {1'b0, oct_idx} - 4'd1);
        active   = ({1'b0, oct_idx} < cfg.oct_num);
        term_ext = SUM_W'(term_reg) <<< sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CELL_STG-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car_reg[0] <= in_carry;
            for (int s = 1; s < CELL_STG; s++) begin
                car_reg[s] <= car_reg[s-1];
            end
            // scale by octave frequency
            prod_reg[0] <= px[47:0];
            prod_reg[1] <= py[47:0];
            prod_reg[2] <= pz[47:0];
            // split, t^2 and first hash round
            for (int a = 0; a < 3; a++) begin
                t_reg[a]  <= prod_reg[a][15:0];
                t2_reg[a] <= 16'((32'(prod_reg[a][15:0]) * 32'(prod_reg[a][15:0])) >> 16);
            end
            cy_reg    <= prod_reg[1][47:16];
            cz_reg    <= prod_reg[2][47:16];
            hx_reg[0] <= fnv_step(FNV_OFFSET, prod_reg[0][47:16]);
            hx_reg[1] <= fnv_step(FNV_OFFSET, prod_reg[0][47:16] + 32'd1);
            // smoothstep and second hash round
            for (int a = 0; a < 3; a++) begin
                w3_reg[a] <= 16'((34'(t2_reg[a])
                             * 34'(18'd196608 - {1'b0, t_reg[a], 1'b0})) >> 16);
            end
            for (int a = 0; a < 2; a++) begin
                hxy_reg[a*2]   <= fnv_step(hx_reg[a], cy_reg);
                hxy_reg[a*2+1] <= fnv_step(hx_reg[a], cy_reg + 32'd1);
            end
            cz3_reg <= cz_reg;
            // third hash round
            for (int j = 0; j < 4; j++) begin
                hxyz_reg[j*2]   <= fnv_step(hxy_reg[j], cz3_reg);
                hxyz_reg[j*2+1] <= fnv_step(hxy_reg[j], cz3_reg + 32'd1);
            end
            w4_reg <= w3_reg;
            // final mix
            for (int j = 0; j < 8; j++) begin
                hm_reg[j] <= 32'((hxyz_reg[j] ^ (hxyz_reg[j] >> 13)) * MIX_MULT);
            end
            w5_reg <= w4_reg;
            // corner index: x*4 + y*2 + z
            for (int j = 0; j < 4; j++) begin
                lx_reg[j] <= blend(cv[j], cv[4+j], w5_reg[0]);
            end
            w6_reg[0] <= w5_reg[1];
            w6_reg[1] <= w5_reg[2];
            ly_reg[0] <= blend(lx_reg[0], lx_reg[2], w6_reg[0]);
            ly_reg[1] <= blend(lx_reg[1], lx_reg[3], w6_reg[0]);
            w7_reg    <= w6_reg[1];
            n_reg     <= blend(ly_reg[0], ly_reg[1], w7_reg);
            term_reg  <= cfg.ridged ? $signed({1'b0, ridge_sq[32:16]}) : n_reg;
        end
    end

    always_comb begin
        out_carry = car_reg[CELL_STG-1];
        if (active) begin
            out_carry.sum = car_reg[CELL_STG-1].sum + term_ext;
        end
    end

    assign out_vld = vld_reg[CELL_STG-1];

endmodule

[hdl/fbm_value_noise_3d_unit.sv]
// ----------------------------------------------------------------------------
// fbm_value_noise_3d_unit
// Fractal value noise over up to eight octaves, one sample point per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item is a sample point, three signed Q7.16 coordinates.
//   m_ channel: one item is the normalised noise value, signed Q1.16,
//     clamped to -1..1 (plain) or 0..1 (ridged).
//   cfg_ port: write base_frequency (0), octave_count (1), ridged_mode (2)
//     with cfg_wr_en; only while the unit is idle. Other indexes are ignored.
// Structure: a chain of eight octave cells, each a 9-stage pipeline, then
//   a two-stage normalise/clamp and the output register.
// Throughput: one item per cycle while no stall or table rebuild holds
//   the input; every stage advances on the same enable.
// Frequency table: rebuilt after reset and after each write of
//   base_frequency or ridged_mode; ridged mode adds a shift-and-add divide
//   by ten for each octave step. s_tready stays low meanwhile.
// Stall: when the output register holds an item and m_tready is low the
//   whole pipeline freezes and s_tready drops; nothing is lost.
// Reset: synchronous, active low; clears valid bits and restores the
//   configuration defaults (65536, 4 octaves, plain).
// ----------------------------------------------------------------------------
module fbm_value_noise_3d_unit
    import fbmv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,
    // sample points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,     // point_x[23:0], point_y[47:24], point_z[71:48]
    // noise values
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata      // noise_value[17:0], zero pad
);

    logic [23:0] base_freq_reg;
    logic [3:0]  oct_num_reg;
    logic        ridged_reg;

    logic        en;
    logic        busy;
    logic        tab_start;
    freq_tab_t   freq_tab;
    cell_cfg_t   cell_cfg;

    logic        vld   [MAX_OCT+1];
    carry_t      carry [MAX_OCT+1];

    logic                      f1_vld_reg, f2_vld_reg;
    logic signed [47:0]        f1_prod_reg;
    logic                      f1_zero_reg;
    logic signed [NOISE_W-1:0] out_reg;
    logic                      m_vld_reg;

    logic signed [47:0]        rnd;
    logic signed [27:0]        scaled;
    logic signed [NOISE_W-1:0] clamped;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_freq_reg <= 24'd65536;
            oct_num_reg   <= 4'd4;
            ridged_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_FREQ: base_freq_reg <= cfg_wr_data;
                REG_OCT_NUM:   oct_num_reg   <= cfg_wr_data[3:0];
                REG_RIDGED:    ridged_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign tab_start = cfg_wr_en && ((cfg_addr == REG_BASE_FREQ) || (cfg_addr == REG_RIDGED));

    fbmv_freq_gen u_freq_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (tab_start),
        .base_freq (base_freq_reg),
        .ridged    (ridged_reg),
        .busy      (busy),
        .freq_tab  (freq_tab)
    );

    // octave counts above the maximum use all cells
    assign cell_cfg.oct_num = (oct_num_reg > 4'(MAX_OCT)) ? 4'(MAX_OCT) : oct_num_reg;
    assign cell_cfg.ridged  = ridged_reg;

    // one enable for the whole pipeline
    assign en       = !m_vld_reg || m_tready;
    assign s_tready = en && !busy;

    assign vld[0]         = s_tvalid && s_tready;
    assign carry[0].x     = $signed(s_tdata[23:0]);
    assign carry[0].y     = $signed(s_tdata[47:24]);
    assign carry[0].z     = $signed(s_tdata[71:48]);
    assign carry[0].sum   = '0;

    for (genvar i = 0; i < MAX_OCT; i++) begin : g_cell
        fbmv_octave_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .oct_idx   (OCT_W'(i)),
            .freq      (freq_tab[i]),
            .cfg       (cell_cfg),
            .in_vld    (vld[i]),
            .in_carry  (carry[i]),
            .out_vld   (vld[i+1]),
            .out_carry (carry[i+1])
        );
    end

    // divide by 2^k - 1 through the reciprocal, round, clamp
    always_comb begin
        rnd    = f1_prod_reg + 48'sd524288;
        scaled = 28'(rnd >>> RECIP_SH);
        if (f1_zero_reg) begin
            clamped = '0;
        end else if (scaled > 28'sd65536) begin
            clamped = 18'sd65536;
        end else if (scaled < -28'sd65536) begin
            clamped = -18'sd65536;
        end else begin
            clamped = scaled[NOISE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= vld[MAX_OCT];
            f2_vld_reg <= f1_vld_reg;
            m_vld_reg  <= f2_vld_reg;
        end
    end

    logic signed [NOISE_W-1:0] f2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_prod_reg <= carry[MAX_OCT].sum * $signed({1'b0, recip(cell_cfg.oct_num)});
            f1_zero_reg <= (cell_cfg.oct_num == '0);
            f2_reg      <= clamped;
            out_reg     <= f2_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule

[test/fbmv_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbmv_checker
// Watches the configuration port and both streams of the noise unit, works out
// the expected noise value for each accepted sample point and compares.
// ----------------------------------------------------------------------------
module fbmv_checker
    import fbmv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          mismatch_count,
    output int          pending_count
);

    localparam longint ONE = 64'sd1 << FRAC_W;

    logic [23:0]        cur_freq;
    logic [3:0]         cur_octaves;
    logic               cur_ridged;
    logic [NOISE_W-1:0] noise_q[$];

    function automatic longint corner_val(bit [31:0] x, bit [31:0] y, bit [31:0] z);
        bit [31:0] h;
        h = FNV_OFFSET;
        h = (h ^ x) * FNV_PRIME;
        h = (h ^ y) * FNV_PRIME;
        h = (h ^ z) * FNV_PRIME;
        h = h ^ (h >> 13);
        h = h * MIX_MULT;
        return longint'(h >> (31 - FRAC_W)) - ONE;
    endfunction

    function automatic longint mix(longint a, longint b, longint w);
        return a + (((b - a) * w) >>> FRAC_W);
    endfunction

    // lattice corner and smoothstep weight along one axis
    function automatic void split(longint p, longint f, output bit [31:0] lat_cell,
                                  output longint w);
        bit [63:0] prod;
        longint    t, t2;
        prod     = 64'(p) * 64'(f);
        lat_cell = prod[47:16];
        t        = longint'(prod[15:0]);
        t2       = (t * t) >>> FRAC_W;
        w        = (t2 * (3 * ONE - 2 * t)) >>> FRAC_W;
    endfunction

    function automatic longint octave_noise(longint px, longint py, longint pz, longint f);
        bit [31:0] ix, iy, iz, jx, jy, jz;
        longint    wx, wy, wz, x00, x10, x01, x11;
        split(px, f, ix, wx);
        split(py, f, iy, wy);
        split(pz, f, iz, wz);
        jx = ix + 1;
        jy = iy + 1;
        jz = iz + 1;
        x00 = mix(corner_val(ix, iy, iz), corner_val(jx, iy, iz), wx);
        x10 = mix(corner_val(ix, jy, iz), corner_val(jx, jy, iz), wx);
        x01 = mix(corner_val(ix, iy, jz), corner_val(jx, iy, jz), wx);
        x11 = mix(corner_val(ix, jy, jz), corner_val(jx, jy, jz), wx);
        return mix(mix(x00, x10, wy), mix(x01, x11, wy), wz);
    endfunction

    function automatic logic [NOISE_W-1:0] fractal_noise(logic [71:0] pt);
        longint px, py, pz, f, sum, n, r, recip_k, res;
        int     k;
        px = longint'($signed(pt[23:0]));
        py = longint'($signed(pt[47:24]));
        pz = longint'($signed(pt[71:48]));
        k  = (cur_octaves > MAX_OCT) ? MAX_OCT : cur_octaves;
        if (k == 0)
            return '0;
        f   = longint'(cur_freq);
        sum = 0;
        for (int i = 0; i < k; i++) begin
            n = octave_noise(px, py, pz, f);
            if (cur_ridged) begin
                r   = ONE - ((n < 0) ? -n : n);
                sum += ((r * r) >>> FRAC_W) <<< (k - 1 - i);
                f   = (f * 21 + 5) / 10;
            end else begin
                sum += n <<< (k - 1 - i);
                f   = f <<< 1;
            end
        end
        recip_k = (((64'sd1 << (RECIP_SH + 1)) / ((64'sd1 << k) - 1)) + 1) >>> 1;
        res = (sum * recip_k + (64'sd1 << (RECIP_SH - 1))) >>> RECIP_SH;
        if (res > ONE)  res = ONE;
        if (res < -ONE) res = -ONE;
        return res[NOISE_W-1:0];
    endfunction

    task automatic report(string what, logic [NOISE_W-1:0] got, logic [NOISE_W-1:0] want);
        $display("%0t: %s: noise_value got %0d want %0d", $time, what,
                 $signed(got), $signed(want));
        mismatch_count++;
    endtask

    initial mismatch_count = 0;
    assign pending_count = noise_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_freq    <= 24'd65536;
            cur_octaves <= 4'd4;
            cur_ridged  <= 1'b0;
            noise_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BASE_FREQ: cur_freq    <= cfg_wr_data;
                    REG_OCT_NUM:   cur_octaves <= cfg_wr_data[3:0];
                    REG_RIDGED:    cur_ridged  <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                noise_q.push_back(fractal_noise(s_tdata));
            if (m_tvalid && m_tready) begin
                if (noise_q.size() == 0)
                    report("unexpected item", m_tdata[NOISE_W-1:0], '0);
                else if (m_tdata[NOISE_W-1:0] !== noise_q[0])
                    report("mismatch", m_tdata[NOISE_W-1:0], noise_q.pop_front());
                else
                    void'(noise_q.pop_front());
            end
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives sample points through the fractal noise unit under a range of register
// settings and idling patterns; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import fbmv_pkg::*;

    localparam int LATENCY   = 75;
    localparam int WDOG_MAX  = 8000;   // covers ridged table rebuild and long hold-off
    localparam int HOLD_LEN  = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int mismatch_count, pending_count;
    int idle_mode = 0;          // 0 none, 1 sender, 2 receiver, 3 both
    bit hold_req = 1'b0;
    int points_sent = 0;
    int settings_used = 0;
    int wdog = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    fbm_value_noise_3d_unit dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    fbmv_checker chk (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .mismatch_count, .pending_count
    );

    // Receiver: random stalls per phase, plus one long hold-off on request
    always @(negedge aclk) begin
        int hold_left;
        if (hold_req && hold_left == 0)
            hold_left = HOLD_LEN;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (idle_mode == 2) begin
            m_tready <= ($urandom_range(99) >= 69);
        end else if (idle_mode == 3) begin
            m_tready <= ($urandom_range(99) >= 33);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("Timeout with %0d items outstanding", pending_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] addr, logic [23:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_point(logic [71:0] pt);
        @(negedge aclk);
        while ((idle_mode == 1 && $urandom_range(99) < 69) ||
               (idle_mode == 3 && $urandom_range(99) < 33)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic set_mode(logic [23:0] freq, logic [3:0] octs, logic ridged);
        drain();
        write_reg(REG_BASE_FREQ, freq);
        write_reg(REG_OCT_NUM, {20'd0, octs});
        write_reg(REG_RIDGED, {23'd0, ridged});
        settings_used++;
    endtask

    // mostly small coordinates, some across the whole field range
    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0:       return 24'($urandom());
            1:       return 24'($signed($urandom_range(65535 * 8)) - 65536 * 4);
            2:       return 24'($urandom_range(1) ? 24'h7FFFFF - $urandom_range(255)
                                                  : 24'h800000 + $urandom_range(255));
            default: return 24'($signed($urandom_range(2097151)) - 1048576);
        endcase
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point({rand_coord(), rand_coord(), rand_coord()});
    endtask

    initial begin
        logic [71:0] directed[$];
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        // Directed: reset settings, coordinate extremes and lattice edges
        directed = '{72'h0,
                     {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF},
                     {24'h800000, 24'h800000, 24'h800000},
                     {24'h800000, 24'h7FFFFF, 24'h000000},
                     {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
                     {24'h00FFFF, 24'h00FFFF, 24'h00FFFF},
                     {24'h010000, 24'hFF0000, 24'h008000},
                     {24'h555555, 24'hAAAAAA, 24'h123456}};
        foreach (directed[i]) send_point(directed[i]);

        // zero octaves, then out of range octave count, then extremes of frequency
        set_mode(24'd65536, 4'd0, 1'b0);
        foreach (directed[i]) send_point(directed[i]);
        set_mode(24'hFFFFFF, 4'd15, 1'b1);
        foreach (directed[i]) send_point(directed[i]);
        set_mode(24'd0, 4'd1, 1'b0);
        send_point(directed[1]);
        send_point(directed[2]);

        // Random phases cycling the idling patterns over many settings
        for (int ph = 0; ph < 12; ph++) begin
            idle_mode = ph % 4;
            case (ph)
                0:  set_mode(24'd65536, 4'd4, 1'b0);
                1:  set_mode(24'hFFFFFF, 4'd8, 1'b0);
                2:  set_mode(24'd0, 4'd8, 1'b1);
                3:  set_mode(24'd1, 4'd1, 1'b1);
                4:  set_mode(24'h020000, 4'd15, 1'b0);
                5:  set_mode(24'd65536, 4'd8, 1'b1);
                6:  set_mode(24'hFFFFFF, 4'd1, 1'b1);
                7:  set_mode(24'd32768, 4'd3, 1'b0);
                default: set_mode(24'($urandom()), 4'($urandom_range(15)), 1'($urandom()));
            endcase
            random_points(114);
        end

        // Pressure: long receiver hold-off while points keep coming
        idle_mode = 0;
        set_mode(24'd98304, 4'd5, 1'b0);
        hold_req = 1'b1;
        repeat (2) @(negedge aclk);
        hold_req = 1'b0;
        random_points(120);
        // sender waits until every result is back, then carries on
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        random_points(40);

        drain();
        $display("Sent %0d sample points over %0d register settings,", points_sent,
                 settings_used);
        $display("plain and ridged, 0 to 15 octaves, with stalls on both sides.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hdl/fbmv_pkg.sv
hdl/fbmv_freq_gen.sv
hdl/fbmv_octave_cell.sv
hdl/fbm_value_noise_3d_unit.sv
test/fbmv_checker.sv
test/tb.sv
